// ===== hdl/simpr_pkg.sv =====
package simpr_pkg;

  // Cell width as seen at the input; the 64-bit form is sign extended to this.
  localparam int unsigned CELL_W    = 128;
  // Bits left for the chain after the entry stage has taken the sign and one bit.
  localparam int unsigned DATA_W    = CELL_W - 2;
  // Bits reduced by each cell per cycle while the chain is enabled.
  localparam int unsigned CELL_BITS = 2;
  localparam int unsigned NUM_CELLS = DATA_W / CELL_BITS;

  localparam int unsigned REG_W     = 32;
  localparam int unsigned RES_W     = 32;
  localparam int unsigned IN_TDATA_W  = 128;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [REG_W-1:0] MODULUS_RESET = 32'd1000003;

  typedef enum logic [0:0] {
    CFG_WIDE_MODE = 1'b0,
    CFG_MODULUS   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SIGN_ZERO = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_class_e;

  // What travels along the chain beside the running residue.
  typedef struct packed {
    sign_class_e        cls;
    logic [DATA_W-1:0]  bits;
  } cell_flow_t;

  typedef struct packed {
    sign_class_e        cls;
    logic [RES_W-1:0]   residue;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } fifo_stat_t;

endpackage

// ===== hdl/simpr_cell.sv =====
module simpr_cell #(
  parameter int unsigned MW = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic [MW-1:0]           mod_i,
  input  logic                    valid_i,
  input  logic [MW-1:0]           acc_i,
  input  simpr_pkg::cell_flow_t   flow_i,
  output logic                    valid_o,
  output logic [MW-1:0]           acc_o,
  output simpr_pkg::cell_flow_t   flow_o
);

  logic                  valid_q;
  logic [MW-1:0]         acc_q, acc_d;
  simpr_pkg::cell_flow_t flow_q, flow_d;

  // acc stays below mod, so 2*acc+bit < 2*mod: one conditional subtract per bit
  always_comb begin
    logic [MW:0]   t;
    logic [MW-1:0] a;
    a = acc_i;
    for (int k = 0; k < simpr_pkg::CELL_BITS; k++) begin
      t = {a, flow_i.bits[simpr_pkg::DATA_W-1-k]};
      if (t >= {1'b0, mod_i}) begin
        t = t - {1'b0, mod_i};
      end
      a = t[MW-1:0];
    end
    acc_d       = a;
    flow_d.cls  = flow_i.cls;
    flow_d.bits = flow_i.bits << simpr_pkg::CELL_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q  <= acc_d;
      flow_q <= flow_d;
    end
  end

  assign valid_o = valid_q;
  assign acc_o   = acc_q;
  assign flow_o  = flow_q;

endmodule

// ===== hdl/simpr_out_fifo.sv =====
module simpr_out_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  simpr_pkg::out_item_t   item_i,
  input  logic                   pop_i,
  output simpr_pkg::out_item_t   item_o,
  output simpr_pkg::fifo_stat_t  stat_o
);

  simpr_pkg::out_item_t mem_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           cnt_q, cnt_d;
  logic                 do_pop;

  assign do_pop = pop_i && (cnt_q != 2'd0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign stat_o.valid = (cnt_q != 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);

endmodule

// ===== hdl/signed_int_mod_prime_reducer.sv =====
// Signed cell reducer: takes one 64- or 128-bit two's-complement cell per cycle and returns
// its value modulo the configured modulus (0 if the modulus is below two) with a zero,
// positive or negative class. The value is reduced MSB first: the sign bit seeds the residue
// with modulus-1 (that is, -1), then each bit doubles and adds, with one compare-subtract
// per bit. An entry stage takes the sign and one bit, a chain of 63 cells takes two bits
// each, and a two-entry output queue decouples the consumer, so throughput is one cell per
// cycle while the consumer keeps up; the input stalls only once the output queue holds two
// unread results. Registers may only be written while the block holds no request in
// flight.
module signed_int_mod_prime_reducer #(
  parameter int unsigned MODULUS_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [simpr_pkg::REG_W-1:0]         cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // word_low [63:0], word_high [127:64]
  input  logic [simpr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // residue [31:0], sign_class [33:32], zero [39:34]
  output logic [simpr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned MW = (MODULUS_BITS < simpr_pkg::REG_W) ? MODULUS_BITS
                                                                 : simpr_pkg::REG_W;

  logic          wide_q;
  logic [MW-1:0] mod_q;
  logic          mod_small;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b0;
      mod_q  <= simpr_pkg::MODULUS_RESET[MW-1:0];
    end else if (cfg_we_i) begin
      unique case (simpr_pkg::cfg_idx_e'(cfg_idx_i))
        simpr_pkg::CFG_WIDE_MODE: wide_q <= cfg_data_i[0];
        simpr_pkg::CFG_MODULUS:   mod_q  <= cfg_data_i[MW-1:0];
        default: ;
      endcase
    end
  end

  assign mod_small = (mod_q < MW'(2));

  simpr_pkg::fifo_stat_t fifo_stat;
  simpr_pkg::out_item_t  fifo_item, push_item;
  logic                  en;

  assign en            = !fifo_stat.full;
  assign s_axis_tready = en;

  // Entry stage: sign extend, classify, seed with the sign and reduce the next bit
  logic [63:0]                 word_lo, word_hi;
  logic [simpr_pkg::CELL_W-1:0] ext;
  logic                        neg, is_zero;
  logic [MW-1:0]               seed, e_acc_d;
  logic [MW:0]                 e_t;
  simpr_pkg::cell_flow_t       e_flow_d;

  assign word_lo = s_axis_tdata[63:0];
  assign word_hi = s_axis_tdata[127:64];

  always_comb begin
    ext     = wide_q ? {word_hi, word_lo} : {{64{word_lo[63]}}, word_lo};
    neg     = ext[simpr_pkg::CELL_W-1];
    is_zero = (word_lo == 64'd0) && (!wide_q || (word_hi == 64'd0));
    seed    = neg ? (mod_q - MW'(1)) : '0;
    e_t     = {seed, ext[simpr_pkg::CELL_W-2]};
    if (e_t >= {1'b0, mod_q}) begin
      e_t = e_t - {1'b0, mod_q};
    end
    e_acc_d = e_t[MW-1:0];
    priority if (is_zero) begin
      e_flow_d.cls = simpr_pkg::SIGN_ZERO;
    end else if (neg) begin
      e_flow_d.cls = simpr_pkg::SIGN_NEG;
    end else begin
      e_flow_d.cls = simpr_pkg::SIGN_POS;
    end
    e_flow_d.bits = ext[simpr_pkg::DATA_W-1:0];
  end

  logic                  c_valid [simpr_pkg::NUM_CELLS+1];
  logic [MW-1:0]         c_acc   [simpr_pkg::NUM_CELLS+1];
  simpr_pkg::cell_flow_t c_flow  [simpr_pkg::NUM_CELLS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid[0] <= 1'b0;
    end else if (en) begin
      c_valid[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_acc[0]  <= e_acc_d;
      c_flow[0] <= e_flow_d;
    end
  end

  for (genvar g = 0; g < simpr_pkg::NUM_CELLS; g++) begin : g_cell
    simpr_cell #(
      .MW (MW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .mod_i   (mod_q),
      .valid_i (c_valid[g]),
      .acc_i   (c_acc[g]),
      .flow_i  (c_flow[g]),
      .valid_o (c_valid[g+1]),
      .acc_o   (c_acc[g+1]),
      .flow_o  (c_flow[g+1])
    );
  end

  always_comb begin
    push_item.residue = '0;
    if (!mod_small) begin
      push_item.residue[MW-1:0] = c_acc[simpr_pkg::NUM_CELLS];
    end
    push_item.cls = c_flow[simpr_pkg::NUM_CELLS].cls;
  end

  simpr_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (en && c_valid[simpr_pkg::NUM_CELLS]),
    .item_i (push_item),
    .pop_i  (m_axis_tready),
    .item_o (fifo_item),
    .stat_o (fifo_stat)
  );

  assign m_axis_tvalid = fifo_stat.valid;
  assign m_axis_tdata  = {6'd0, fifo_item.cls, fifo_item.residue};

endmodule

// ===== hdl/simpr_checker.sv =====
module simpr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // result request held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_class_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[33:32] == simpr_pkg::SIGN_ZERO)
                   || (m_axis_tdata[33:32] == simpr_pkg::SIGN_POS)
                   || (m_axis_tdata[33:32] == simpr_pkg::SIGN_NEG))
    else $error("bad sign class");

  a_zero_residue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[33:32] == simpr_pkg::SIGN_ZERO)
      |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("zero cell with non-zero residue");

  // a free output queue never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output queue");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39:34] == 6'd0))
    else $error("padding bits set");

endmodule

bind signed_int_mod_prime_reducer simpr_checker u_simpr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LATENCY     = 70;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SEG_ITEMS   = 150;
  localparam int unsigned NUM_SEGS    = 13;
  localparam int unsigned NUM_DIR     = 25;

  typedef struct {
    bit                     wide;
    logic [31:0]            modulus;
    logic [63:0]            lo;
    logic [63:0]            hi;
    bit                     typed;
    logic [31:0]            residue;
    simpr_pkg::sign_class_e cls;
  } dir_row_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic                              cfg_idx_i = simpr_pkg::CFG_WIDE_MODE;
  logic [simpr_pkg::REG_W-1:0]       cfg_data_i = '0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [simpr_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [simpr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  // model copy of the registers
  bit          cur_wide = 1'b0;
  logic [31:0] cur_mod  = simpr_pkg::MODULUS_RESET;

  simpr_pkg::out_item_t owed_residues [$];
  int unsigned mismatches   = 0;
  int unsigned cycles       = 0;
  int unsigned src_idle_pct = 11;
  int unsigned rcv_idle_pct = 76;

  dir_row_t dir_tab [0:NUM_DIR-1] = '{
    '{1'b0, 32'd1000003, 64'd0, 64'd0, 1'b1, 32'd0, simpr_pkg::SIGN_ZERO},
    '{1'b0, 32'd1000003, 64'd0, '1, 1'b1, 32'd0, simpr_pkg::SIGN_ZERO},
    '{1'b0, 32'd1000003, 64'd1, 64'd0, 1'b1, 32'd1, simpr_pkg::SIGN_POS},
    '{1'b0, 32'd1000003, '1, 64'd0, 1'b1, 32'd1000002, simpr_pkg::SIGN_NEG},
    '{1'b0, 32'd1000003, 64'h7fff_ffff_ffff_ffff, 64'd0, 1'b0, 32'd0, simpr_pkg::SIGN_ZERO},
    '{1'b0, 32'd1000003, 64'h8000_0000_0000_0000, 64'd0, 1'b0, 32'd0, simpr_pkg::SIGN_ZERO},
    '{1'b0, 32'd1000003, 64'd1000003, 64'd0, 1'b1, 32'd0, simpr_pkg::SIGN_POS},
    '{1'b0, 32'd1000003, 64'd1, 64'h8000_0000_0000_0000, 1'b1, 32'd1, simpr_pkg::SIGN_POS},
    '{1'b1, 32'd1000003, 64'd0, 64'd0, 1'b1, 32'd0, simpr_pkg::SIGN_ZERO},
    '{1'b1, 32'd1000003, 64'd1, 64'd0, 1'b1, 32'd1, simpr_pkg::SIGN_POS},
    '{1'b1, 32'd1000003, '1, '1, 1'b1, 32'd1000002, simpr_pkg::SIGN_NEG},
    '{1'b1, 32'd1000003, 64'd0, 64'h8000_0000_0000_0000, 1'b0, 32'd0, simpr_pkg::SIGN_ZERO},
    '{1'b1, 32'd1000003, '1, 64'h7fff_ffff_ffff_ffff, 1'b0, 32'd0, simpr_pkg::SIGN_ZERO},
    '{1'b1, 32'd1000003, 64'd0, 64'd1, 1'b0, 32'd0, simpr_pkg::SIGN_ZERO},
    '{1'b1, 32'd0, 64'd5, 64'd0, 1'b1, 32'd0, simpr_pkg::SIGN_POS},
    '{1'b1, 32'd0, '1, '1, 1'b1, 32'd0, simpr_pkg::SIGN_NEG},
    '{1'b0, 32'd1, '1, 64'd0, 1'b1, 32'd0, simpr_pkg::SIGN_NEG},
    '{1'b0, 32'd1, 64'd0, 64'd0, 1'b1, 32'd0, simpr_pkg::SIGN_ZERO},
    '{1'b0, 32'd2, 64'd3, 64'd0, 1'b1, 32'd1, simpr_pkg::SIGN_POS},
    '{1'b0, 32'd2, '1, 64'd0, 1'b1, 32'd1, simpr_pkg::SIGN_NEG},
    '{1'b1, 32'hffff_ffff, '1, '1, 1'b1, 32'hffff_fffe, simpr_pkg::SIGN_NEG},
    '{1'b1, 32'hffff_ffff, 64'hffff_ffff, 64'd0, 1'b1, 32'd0, simpr_pkg::SIGN_POS},
    '{1'b0, 32'hffff_fffb, 64'h8000_0000_0000_0000, 64'd0, 1'b0, 32'd0, simpr_pkg::SIGN_ZERO},
    // modulus not prime
    '{1'b1, 32'd12, 64'hffff_ffff_ffff_fff9, '1, 1'b1, 32'd5, simpr_pkg::SIGN_NEG},
    '{1'b0, 32'd12, 64'hffff_ffff_ffff_fff9, 64'd0, 1'b1, 32'd5, simpr_pkg::SIGN_NEG}
  };

  signed_int_mod_prime_reducer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("signed_int_mod_prime_reducer regression: fail");
      $finish;
    end
  end

  // residue of the signed cell under the current register copy
  function automatic simpr_pkg::out_item_t reduce_cell(input logic [63:0] lo,
                                                      input logic [63:0] hi);
    simpr_pkg::out_item_t r;
    logic [63:0] hi_eff;
    logic [63:0] m;
    logic [63:0] acc;
    logic [63:0] wrap;
    logic [127:0] val;
    bit          neg;
    int          k;
    hi_eff = cur_wide ? hi : 64'd0;
    neg    = cur_wide ? hi[63] : lo[63];
    m      = {32'd0, cur_mod};
    acc    = 64'd0;
    if (m >= 64'd2) begin
      val = {hi_eff, lo};
      for (k = (cur_wide ? 15 : 7); k >= 0; k--)
        acc = (acc * 64'd256 + {56'd0, val[8*k +: 8]}) % m;
      wrap = 64'd1 % m;
      for (k = 0; k < (cur_wide ? 128 : 64); k++)
        wrap = (wrap * 64'd2) % m;
      if (neg)
        acc = (acc >= wrap) ? acc - wrap : acc + m - wrap;
    end
    r.residue = acc[31:0];
    if (lo == 64'd0 && hi_eff == 64'd0) r.cls = simpr_pkg::SIGN_ZERO;
    else if (neg)                       r.cls = simpr_pkg::SIGN_NEG;
    else                                r.cls = simpr_pkg::SIGN_POS;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // registers only change once the pipe is empty
  task automatic set_registers(input bit wide, input logic [31:0] modulus);
    while (owed_residues.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = simpr_pkg::CFG_WIDE_MODE;
    cfg_data_i = {31'd0, wide};
    @(negedge clk_i);
    cfg_idx_i  = simpr_pkg::CFG_MODULUS;
    cfg_data_i = modulus;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    cur_wide   = wide;
    cur_mod    = modulus;
  endtask

  // call at a falling edge; returns at a falling edge after the request is taken
  task automatic send_cell(input logic [63:0] lo, input logic [63:0] hi,
                           input bit typed, input simpr_pkg::out_item_t typed_out);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {hi, lo};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    owed_residues.insert(owed_residues.size(), typed ? typed_out : reduce_cell(lo, hi));
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  always @(negedge clk_i)
    m_axis_tready = (rcv_idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= rcv_idle_pct);

  always @(posedge clk_i) begin
    simpr_pkg::out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_residues.size() == 0) begin
        flag_mismatch("result with nothing owed", {24'd0, m_axis_tdata}, 64'd0);
      end else begin
        want = owed_residues.pop_front();
        if (m_axis_tdata[31:0] !== want.residue)
          flag_mismatch("residue", {32'd0, m_axis_tdata[31:0]}, {32'd0, want.residue});
        if (m_axis_tdata[33:32] !== want.cls)
          flag_mismatch("sign_class", {62'd0, m_axis_tdata[33:32]}, {62'd0, want.cls});
      end
    end
  end

  initial begin
    simpr_pkg::out_item_t typed_out;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [31:0] modulus;
    logic [63:0] low_mag;
    int unsigned seg;
    int unsigned n;
    int unsigned sent;
    int unsigned kind;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (n = 0; n < NUM_DIR; n++) begin
      if (dir_tab[n].wide != cur_wide || dir_tab[n].modulus != cur_mod)
        set_registers(dir_tab[n].wide, dir_tab[n].modulus);
      typed_out.residue = dir_tab[n].residue;
      typed_out.cls     = dir_tab[n].cls;
      send_cell(dir_tab[n].lo, dir_tab[n].hi, dir_tab[n].typed, typed_out);
    end

    sent = 0;
    for (seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg)
        0:       modulus = 32'd2;
        1:       modulus = 32'hffff_ffff;
        2:       modulus = 32'd1000003;
        3:       modulus = 32'd3;
        4:       modulus = 32'hffff_fffb;
        5:       modulus = 32'd0;
        7:       modulus = 32'd65521;
        8:       modulus = 32'd1;
        10:      modulus = 32'h7fff_ffff;
        12:      modulus = 32'd7;
        default: modulus = $urandom;
      endcase
      set_registers(seg[0], modulus);
      for (n = 0; n < SEG_ITEMS; n++) begin
        if (sent == 650) begin
          src_idle_pct = 76;
          rcv_idle_pct = 11;
        end else if (sent == 1300) begin
          src_idle_pct = 0;
          rcv_idle_pct = 0;
        end
        kind    = $urandom_range(9);
        lo      = {$urandom, $urandom};
        hi      = {$urandom, $urandom};
        low_mag = {54'd0, 10'($urandom_range(1023))};
        case (kind)
          4: begin
            lo = low_mag;
            hi = 64'd0;
          end
          5: begin
            lo = -low_mag - 64'd1;
            hi = '1;
          end
          6: begin
            // close to a multiple of the modulus
            lo = {32'd0, cur_mod} * {32'd0, $urandom} + low_mag - 64'd512;
            hi = {64{lo[63]}};
          end
          7: begin
            case ($urandom_range(3))
              0: lo = 64'd0;
              1: lo = 64'h7fff_ffff_ffff_ffff;
              2: lo = 64'h8000_0000_0000_0000;
              default: lo = '1;
            endcase
            hi = ($urandom_range(1) != 0) ? {64{lo[63]}} : {~lo[63], {63{lo[63]}}};
          end
          8: hi = {64{lo[63]}};
          9: lo = 64'd0;
          default: ;
        endcase
        if (!cur_wide && $urandom_range(1) != 0) hi = {$urandom, $urandom};
        send_cell(lo, hi, 1'b0, typed_out);
        sent++;
      end
    end

    while (owed_residues.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("signed_int_mod_prime_reducer regression: pass");
    end else begin
      $display("signed_int_mod_prime_reducer regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/simpr_pkg.sv
hdl/simpr_cell.sv
hdl/simpr_out_fifo.sv
hdl/signed_int_mod_prime_reducer.sv
hdl/simpr_checker.sv
tb/tb.sv
